@@ rtl/twcs_pkg.sv @@
// Shared types and constants for the time weighted channel statistics block.
`default_nettype none
package twcs_pkg;

    localparam int VALUE_W = 32;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 64;
    localparam int GAP_W   = 16;
    localparam int PROD_W  = VALUE_W + GAP_W;
    localparam int CFG_W   = 18;
    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 4;
    localparam int IDX_W   = 3;

    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cmd_t CMD_RECORD = 2'd0;
    localparam cmd_t CMD_QUERY  = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

    localparam cfg_idx_t REG_GAP_CAP   = 3'd0;
    localparam cfg_idx_t REG_SKIP_ZERO = 3'd1;
    localparam cfg_idx_t REG_STALE_SEL = 3'd2;
    localparam cfg_idx_t REG_LIMIT_A   = 3'd3;
    localparam cfg_idx_t REG_LIMIT_B   = 3'd4;
    localparam cfg_idx_t REG_LIMIT_C   = 3'd5;

    localparam logic [15:0] GAP_CAP_RST   = 16'd5000;
    localparam logic [8:0]  SKIP_ZERO_RST = 9'd12;
    localparam logic [17:0] STALE_SEL_RST = 18'd173392;
    localparam logic [15:0] LIMIT_A_RST   = 16'd3000;
    localparam logic [15:0] LIMIT_B_RST   = 16'd6000;
    localparam logic [15:0] LIMIT_C_RST   = 16'd5000;

endpackage
`default_nettype wire

@@ rtl/twcs_mul.sv @@
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module twcs_mul
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [twcs_pkg::VALUE_W-1:0] multiplicand,
    input  wire logic [twcs_pkg::GAP_W-1:0]        multiplier,
    output logic                                   done,
    output logic signed [twcs_pkg::PROD_W-1:0]     product
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [3:0]                       count_reg, count_next;
    logic [twcs_pkg::PROD_W-1:0]      mcand_reg, mcand_next;
    logic [twcs_pkg::GAP_W-1:0]       mplier_reg, mplier_next;
    logic [twcs_pkg::PROD_W-1:0]      acc_reg, acc_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            count_next  = '0;
            mcand_next  = twcs_pkg::PROD_W'(multiplicand);
            mplier_next = multiplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[twcs_pkg::PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[twcs_pkg::GAP_W-1:1]};
            count_next  = count_reg + 4'd1;
            if (count_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

@@ rtl/twcs_div.sv @@
// Restoring serial divider, 64-bit magnitude by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module twcs_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [twcs_pkg::SUM_W-1:0]    dividend,
    input  wire logic [twcs_pkg::TIME_W-1:0]   divisor,
    output logic                               done,
    output logic [twcs_pkg::SUM_W-1:0]         quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [5:0]                      count_reg, count_next;
    logic [twcs_pkg::TIME_W:0]       rem_reg, rem_next;
    logic [twcs_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [twcs_pkg::TIME_W-1:0]     dvs_reg, dvs_next;
    logic [twcs_pkg::TIME_W:0]       rem_sh;
    logic [twcs_pkg::TIME_W+1:0]     diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        rem_sh     = {rem_reg[twcs_pkg::TIME_W-1:0], quo_reg[twcs_pkg::SUM_W-1]};
        diff       = {1'b0, rem_sh} - {2'b00, dvs_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[twcs_pkg::TIME_W+1])
            begin
                rem_next = diff[twcs_pkg::TIME_W:0];
                quo_next = {quo_reg[twcs_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[twcs_pkg::SUM_W-2:0], 1'b0};
            end
            count_next = count_reg + 6'd1;
            if (count_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ rtl/time_weighted_channel_stats.sv @@
// Top level of the time weighted channel statistics block.
// One request at a time. A clear never leaves the idle state. A record needs only the
// prepare state for a first sample or a skipped zero interval, else it also waits on
// the 16-step serial multiplier. A query passes the prepare and finish states, and waits
// on the 64-step serial divider when an average is divided out; a query that finishes
// while the previous result is still uncollected waits for it. A query result sits in an
// output register, so the next request is taken while it waits to be collected.
`default_nettype none
module time_weighted_channel_stats
#(
    parameter int CHANNELS = 9
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [3:0]                    channel,
    input  wire logic signed [31:0]            sample_value,
    input  wire logic [31:0]                   time_ms,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               channel_valid,
    output logic [31:0]                        sample_count,
    output logic signed [31:0]                 current_value,
    output logic signed [31:0]                 lowest_value,
    output logic signed [31:0]                 highest_value,
    output logic signed [31:0]                 average_value,
    output logic                               is_live,
    output logic [31:0]                        session_ms,
    input  wire logic                          cfg_write,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [17:0]                   cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  state_reg, state_next;

    logic [15:0] gap_cap_reg;
    logic [8:0]  skip_zero_reg;
    logic [17:0] stale_sel_reg;
    logic [15:0] limit_a_reg, limit_b_reg, limit_c_reg;
    logic [31:0] session_start_reg;

    logic signed [31:0] latest_reg  [CHANNELS];
    logic signed [31:0] lowest_reg  [CHANNELS];
    logic signed [31:0] highest_reg [CHANNELS];
    logic signed [63:0] sum_reg     [CHANNELS];
    logic [31:0]        covered_reg [CHANNELS];
    logic [31:0]        count_reg   [CHANNELS];
    logic [31:0]        last_reg    [CHANNELS];
    logic [CHANNELS-1:0] seen_reg;

    logic               query_reg;
    logic [3:0]         ch_reg;
    logic signed [31:0] val_reg;
    logic [31:0]        now_reg;
    logic [15:0]        dt_reg;
    logic               neg_reg;

    logic               res_valid_reg;
    logic [31:0]        res_count_reg;
    logic signed [31:0] res_cur_reg, res_low_reg, res_high_reg, res_avg_reg;
    logic               res_live_reg;
    logic [31:0]        res_sess_reg;

    logic               out_valid_reg;
    logic               o_chv_reg, o_live_reg;
    logic [31:0]        o_count_reg, o_sess_reg;
    logic signed [31:0] o_cur_reg, o_low_reg, o_high_reg, o_avg_reg;

    logic [CH_W-1:0]    cidx;
    logic               good;
    logic               seen;
    logic [31:0]        age;
    logic [15:0]        dt_capped;
    logic [8:0]         skip_sh;
    logic [17:0]        sel_sh;
    logic [1:0]         grp;
    logic [15:0]        lim;
    logic               skip;
    logic               accept;
    logic               out_free;

    logic               mul_start, mul_done;
    logic signed [47:0] product;
    logic signed [63:0] prod_ext, sum_new;
    logic               sum_ovf;
    logic [32:0]        cov_new;

    logic               div_start, div_done;
    logic [63:0]        sum_mag, quotient;
    logic signed [31:0] avg_clamped;

    assign cidx     = ch_reg[CH_W-1:0];
    assign good     = {1'b0, ch_reg} < 5'(CHANNELS);
    assign seen     = good && seen_reg[cidx];
    assign age      = now_reg - last_reg[cidx];
    assign dt_capped = (age > {16'd0, gap_cap_reg}) ? gap_cap_reg : age[15:0];
    assign skip_sh  = skip_zero_reg >> ch_reg;
    assign sel_sh   = stale_sel_reg >> {ch_reg, 1'b0};
    assign grp      = sel_sh[1:0];
    assign skip     = skip_sh[0] && (latest_reg[cidx] == 32'sd0);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        case (grp)
            2'd0:    lim = limit_a_reg;
            2'd1:    lim = limit_b_reg;
            default: lim = limit_c_reg;
        endcase
    end

    assign mul_start = (state_reg == S_PREP) && !query_reg && seen && !skip;
    assign div_start = (state_reg == S_PREP) && query_reg && seen && (covered_reg[cidx] != '0);
    assign sum_mag   = sum_reg[cidx][63] ? (64'd0 - sum_reg[cidx]) : sum_reg[cidx];

    twcs_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (latest_reg[cidx]),
        .multiplier   (dt_capped),
        .done         (mul_done),
        .product      (product)
    );

    twcs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (covered_reg[cidx]),
        .done     (div_done),
        .quotient (quotient)
    );

    assign prod_ext = 64'(product);
    assign sum_new  = sum_reg[cidx] + prod_ext;
    assign sum_ovf  = (sum_reg[cidx][63] == prod_ext[63]) && (sum_new[63] != prod_ext[63]);
    assign cov_new  = {1'b0, covered_reg[cidx]} + {17'd0, dt_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            if ((|quotient[63:32]) || (quotient[31] && (|quotient[30:0])))
                avg_clamped = 32'sh8000_0000;
            else
                avg_clamped = 32'(32'd0 - quotient[31:0]);
        end
        else
        begin
            if ((|quotient[63:32]) || quotient[31])
                avg_clamped = 32'sh7FFF_FFFF;
            else
                avg_clamped = quotient[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && (command == twcs_pkg::CMD_QUERY ||
                    (command == twcs_pkg::CMD_RECORD && {1'b0, channel} < 5'(CHANNELS))))
                    state_next = S_PREP;
            S_PREP:
                if (mul_start)
                    state_next = S_MUL;
                else if (div_start)
                    state_next = S_DIV;
                else if (query_reg)
                    state_next = S_FIN;
                else
                    state_next = S_IDLE;
            S_MUL:
                if (mul_done)
                    state_next = S_IDLE;
            S_DIV:
                if (div_done)
                    state_next = S_FIN;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            gap_cap_reg       <= twcs_pkg::GAP_CAP_RST;
            skip_zero_reg     <= twcs_pkg::SKIP_ZERO_RST;
            stale_sel_reg     <= twcs_pkg::STALE_SEL_RST;
            limit_a_reg       <= twcs_pkg::LIMIT_A_RST;
            limit_b_reg       <= twcs_pkg::LIMIT_B_RST;
            limit_c_reg       <= twcs_pkg::LIMIT_C_RST;
            session_start_reg <= '0;
            seen_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    twcs_pkg::REG_GAP_CAP:   gap_cap_reg   <= cfg_data[15:0];
                    twcs_pkg::REG_SKIP_ZERO: skip_zero_reg <= cfg_data[8:0];
                    twcs_pkg::REG_STALE_SEL: stale_sel_reg <= cfg_data;
                    twcs_pkg::REG_LIMIT_A:   limit_a_reg   <= cfg_data[15:0];
                    twcs_pkg::REG_LIMIT_B:   limit_b_reg   <= cfg_data[15:0];
                    twcs_pkg::REG_LIMIT_C:   limit_c_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (accept && command == twcs_pkg::CMD_CLEAR)
            begin
                seen_reg          <= '0;
                session_start_reg <= time_ms;
            end
            if (state_reg == S_PREP && !query_reg)
                seen_reg[cidx] <= 1'b1;
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= (command == twcs_pkg::CMD_QUERY);
            ch_reg    <= channel;
            val_reg   <= sample_value;
            now_reg   <= time_ms;
        end
        if (state_reg == S_PREP)
        begin
            dt_reg  <= dt_capped;
            neg_reg <= sum_reg[cidx][63];
            if (!query_reg)
            begin
                latest_reg[cidx] <= val_reg;
                last_reg[cidx]   <= now_reg;
                if (!seen)
                begin
                    lowest_reg[cidx]  <= val_reg;
                    highest_reg[cidx] <= val_reg;
                    count_reg[cidx]   <= 32'd1;
                    sum_reg[cidx]     <= '0;
                    covered_reg[cidx] <= '0;
                end
                else
                begin
                    if (val_reg < lowest_reg[cidx])
                        lowest_reg[cidx] <= val_reg;
                    if (val_reg > highest_reg[cidx])
                        highest_reg[cidx] <= val_reg;
                    count_reg[cidx] <= count_reg[cidx] + 32'd1;
                end
            end
            else
            begin
                res_sess_reg  <= now_reg - session_start_reg;
                res_valid_reg <= seen;
                res_count_reg <= seen ? count_reg[cidx] : '0;
                res_cur_reg   <= seen ? latest_reg[cidx] : '0;
                res_low_reg   <= seen ? lowest_reg[cidx] : '0;
                res_high_reg  <= seen ? highest_reg[cidx] : '0;
                res_avg_reg   <= seen ? latest_reg[cidx] : '0;
                res_live_reg  <= seen && (grp != 2'd3) && (age < {16'd0, lim});
            end
        end
        if (state_reg == S_MUL && mul_done)
        begin
            if (sum_ovf)
                sum_reg[cidx] <= prod_ext[63] ? 64'sh8000_0000_0000_0000
                                              : 64'sh7FFF_FFFF_FFFF_FFFF;
            else
                sum_reg[cidx] <= sum_new;
            covered_reg[cidx] <= cov_new[32] ? 32'hFFFF_FFFF : cov_new[31:0];
        end
        if (state_reg == S_DIV && div_done)
            res_avg_reg <= avg_clamped;
        if (state_reg == S_FIN && out_free)
        begin
            o_chv_reg   <= res_valid_reg;
            o_count_reg <= res_count_reg;
            o_cur_reg   <= res_cur_reg;
            o_low_reg   <= res_low_reg;
            o_high_reg  <= res_high_reg;
            o_avg_reg   <= res_avg_reg;
            o_live_reg  <= res_live_reg;
            o_sess_reg  <= res_sess_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_valid = o_chv_reg;
    assign sample_count  = o_count_reg;
    assign current_value = o_cur_reg;
    assign lowest_value  = o_low_reg;
    assign highest_value = o_high_reg;
    assign average_value = o_avg_reg;
    assign is_live       = o_live_reg;
    assign session_ms    = o_sess_reg;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for time_weighted_channel_stats: predicts query results and checks them.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = 9;
    localparam int DOG_LIMIT = 20000;
    localparam int SETTLE = 100;
    localparam twcs_pkg::cmd_t CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] count;
        logic [31:0] current;
        logic [31:0] lowest;
        logic [31:0] highest;
        logic [31:0] average;
        logic        live;
        logic [31:0] session;
    } stats_result_t;

    class stats_scoreboard;
        logic [15:0] gap_cap;
        logic [8:0]  skip_mask;
        logic [17:0] stale_sel;
        logic [15:0] limit_a, limit_b, limit_c;
        logic signed [31:0] latest[NCH], lowest[NCH], highest[NCH];
        logic signed [63:0] wsum[NCH];
        logic [31:0] covered[NCH], count[NCH], last_time[NCH];
        logic        seen[NCH];
        logic [31:0] session_start;
        stats_result_t pending[$];
        int errors;

        function new();
            gap_cap = twcs_pkg::GAP_CAP_RST;
            skip_mask = twcs_pkg::SKIP_ZERO_RST;
            stale_sel = twcs_pkg::STALE_SEL_RST;
            limit_a = twcs_pkg::LIMIT_A_RST;
            limit_b = twcs_pkg::LIMIT_B_RST;
            limit_c = twcs_pkg::LIMIT_C_RST;
            session_start = '0;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < NCH; i++)
            begin
                latest[i] = '0; lowest[i] = '0; highest[i] = '0; wsum[i] = '0;
                covered[i] = '0; count[i] = '0; last_time[i] = '0; seen[i] = 1'b0;
            end
        endfunction

        function void set_reg(twcs_pkg::cfg_idx_t idx, logic [17:0] d);
            case (idx)
                twcs_pkg::REG_GAP_CAP:   gap_cap = d[15:0];
                twcs_pkg::REG_SKIP_ZERO: skip_mask = d[8:0];
                twcs_pkg::REG_STALE_SEL: stale_sel = d;
                twcs_pkg::REG_LIMIT_A:   limit_a = d[15:0];
                twcs_pkg::REG_LIMIT_B:   limit_b = d[15:0];
                twcs_pkg::REG_LIMIT_C:   limit_c = d[15:0];
                default: ;
            endcase
        endfunction

        function void note(twcs_pkg::cmd_t c, logic [3:0] ch, logic signed [31:0] v,
                           logic [31:0] now);
            logic [31:0] dt;
            logic signed [63:0] prod;
            logic [64:0] s65;
            logic [32:0] c33;
            longint avg;
            logic [1:0] grp;
            logic [15:0] lim;
            stats_result_t r;
            if (c == twcs_pkg::CMD_CLEAR)
            begin
                wipe();
                session_start = now;
            end
            else if (c == twcs_pkg::CMD_RECORD && ch < NCH)
            begin
                if (!seen[ch])
                begin
                    lowest[ch] = v;
                    highest[ch] = v;
                    seen[ch] = 1'b1;
                end
                else
                begin
                    dt = now - last_time[ch];
                    if (v < lowest[ch]) lowest[ch] = v;
                    if (v > highest[ch]) highest[ch] = v;
                    if (dt > {16'd0, gap_cap}) dt = {16'd0, gap_cap};
                    if (!(skip_mask[ch] && latest[ch] == 0))
                    begin
                        prod = longint'(latest[ch]) * longint'(dt);
                        s65 = {wsum[ch][63], wsum[ch]} + {prod[63], prod};
                        if (s65[64] != s65[63])
                            wsum[ch] = s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        else
                            wsum[ch] = s65[63:0];
                        c33 = {1'b0, covered[ch]} + {1'b0, dt};
                        covered[ch] = c33[32] ? '1 : c33[31:0];
                    end
                end
                latest[ch] = v;
                last_time[ch] = now;
                count[ch] = count[ch] + 32'd1;
            end
            else if (c == twcs_pkg::CMD_QUERY)
            begin
                r = '0;
                r.session = now - session_start;
                if (ch < NCH)
                begin
                    r.count = count[ch];
                    if (seen[ch])
                    begin
                        r.valid = 1'b1;
                        r.current = latest[ch];
                        r.lowest = lowest[ch];
                        r.highest = highest[ch];
                        if (covered[ch] != 0)
                        begin
                            avg = wsum[ch] / longint'(covered[ch]);
                            if (avg > 64'sd2147483647) avg = 64'sd2147483647;
                            if (avg < -64'sd2147483648) avg = -64'sd2147483648;
                            r.average = avg[31:0];
                        end
                        else
                            r.average = latest[ch];
                        grp = stale_sel[2*ch +: 2];
                        lim = grp == 0 ? limit_a : grp == 1 ? limit_b : limit_c;
                        r.live = grp != 2'd3 && (now - last_time[ch]) < {16'd0, lim};
                    end
                end
                pending.push_back(r);
            end
        endfunction

        function void field(string n, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $display("%0t: %s expected %h actual %h", $time, n, e, a);
                errors++;
            end
        endfunction

        function void check(stats_result_t got);
            stats_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            field("channel_valid", {31'd0, e.valid}, {31'd0, got.valid});
            field("sample_count", e.count, got.count);
            field("current_value", e.current, got.current);
            field("lowest_value", e.lowest, got.lowest);
            field("highest_value", e.highest, got.highest);
            field("average_value", e.average, got.average);
            field("is_live", {31'd0, e.live}, {31'd0, got.live});
            field("session_ms", e.session, got.session);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = '0;
    logic [3:0] channel = '0;
    logic signed [31:0] sample_value = '0;
    logic [31:0] time_ms = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic channel_valid, is_live;
    logic [31:0] sample_count, session_ms;
    logic signed [31:0] current_value, lowest_value, highest_value, average_value;
    logic cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [17:0] cfg_data = '0;

    stats_scoreboard sb = new();
    logic quiet = 1'b0;
    logic [31:0] clock_ms = 32'd100;
    int idle_cycles = 0;

    time_weighted_channel_stats #(.CHANNELS(NCH)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check({channel_valid, sample_count, current_value, lowest_value, highest_value,
                      average_value, is_live, session_ms});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    always
    begin
        @(posedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    task automatic send(twcs_pkg::cmd_t c, logic [3:0] ch, logic [31:0] v, logic [31:0] t);
        in_valid <= 1'b1;
        command <= c;
        channel <= ch;
        sample_value <= v;
        time_ms <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note(c, ch, v, t);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(twcs_pkg::cfg_idx_t idx, logic [17:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] gap, logic [8:0] mask, logic [17:0] sel,
                             logic [15:0] la, logic [15:0] lb, logic [15:0] lc);
        drain();
        write_reg(twcs_pkg::REG_GAP_CAP, 18'(gap));
        write_reg(twcs_pkg::REG_SKIP_ZERO, 18'(mask));
        write_reg(twcs_pkg::REG_STALE_SEL, sel);
        write_reg(twcs_pkg::REG_LIMIT_A, 18'(la));
        write_reg(twcs_pkg::REG_LIMIT_B, 18'(lb));
        write_reg(twcs_pkg::REG_LIMIT_C, 18'(lc));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return 32'h7fffffff;
            3:       return 32'h80000000;
            4, 5:    return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] step_time();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1, 2:    return '0;
            3:       return $urandom_range(60000, 70000);
            default: return $urandom_range(1, 7000);
        endcase
    endfunction

    task automatic random_phase(int n);
        twcs_pkg::cmd_t c;
        logic [3:0] ch;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 39))
                0:        c = twcs_pkg::CMD_CLEAR;
                1:        c = CMD_UNUSED;
                default:  c = $urandom_range(0, 1) ? twcs_pkg::CMD_QUERY : twcs_pkg::CMD_RECORD;
            endcase
            ch = 4'($urandom_range(0, 11) == 0 ? $urandom_range(NCH, 15)
                                               : $urandom_range(0, NCH - 1));
            clock_ms = clock_ms + step_time();
            send(c, ch, pick_value(), clock_ms);
            maybe_gap();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, skipped zeros, wrap, bad channels, unused command
        send(twcs_pkg::CMD_QUERY, 4'd0, '0, 32'd50);
        send(twcs_pkg::CMD_CLEAR, 4'd15, 32'hffffffff, 32'd1000);
        send(twcs_pkg::CMD_RECORD, 4'd0, 32'h7fffffff, 32'd1000);
        send(twcs_pkg::CMD_RECORD, 4'd0, 32'h80000000, 32'd2000);
        send(twcs_pkg::CMD_RECORD, 4'd0, 32'h7fffffff, 32'd90000);
        send(twcs_pkg::CMD_QUERY, 4'd0, '0, 32'd91000);
        send(twcs_pkg::CMD_RECORD, 4'd2, '0, 32'd1000);
        send(twcs_pkg::CMD_RECORD, 4'd2, 32'd256, 32'd3000);
        send(twcs_pkg::CMD_RECORD, 4'd2, 32'd512, 32'd4000);
        send(twcs_pkg::CMD_QUERY, 4'd2, '0, 32'd4000);
        send(twcs_pkg::CMD_RECORD, 4'd8, -32'sd5, 32'hfffff000);
        send(twcs_pkg::CMD_RECORD, 4'd8, 32'd7, 32'd100);
        send(twcs_pkg::CMD_QUERY, 4'd8, '0, 32'd200);
        send(twcs_pkg::CMD_QUERY, 4'd5, '0, 32'hffffffff);
        send(twcs_pkg::CMD_RECORD, 4'd9, 32'd1, 32'd5);
        send(twcs_pkg::CMD_RECORD, 4'd15, 32'd1, 32'd5);
        send(twcs_pkg::CMD_QUERY, 4'd15, '0, 32'd6);
        send(twcs_pkg::CMD_QUERY, 4'd9, '0, 32'd6);
        send(CMD_UNUSED, 4'd1, 32'd1, 32'd7);
        send(twcs_pkg::CMD_QUERY, 4'd1, '0, 32'd8);
        send(twcs_pkg::CMD_RECORD, 4'd4, 32'd100, 32'd10);
        send(twcs_pkg::CMD_QUERY, 4'd4, '0, 32'd10);
        send(twcs_pkg::CMD_QUERY, 4'd4, '0, 32'd20000);

        random_phase(380);
        write_all('0, '0, '0, '0, '0, '0);
        random_phase(300);
        write_all(16'hffff, 9'h1ff, 18'h3ffff, 16'hffff, 16'hffff, 16'hffff);
        random_phase(300);
        write_all(16'($urandom), 9'($urandom), 18'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        random_phase(300);
        write_all(twcs_pkg::GAP_CAP_RST, twcs_pkg::SKIP_ZERO_RST, twcs_pkg::STALE_SEL_RST,
                  twcs_pkg::LIMIT_A_RST, twcs_pkg::LIMIT_B_RST, twcs_pkg::LIMIT_C_RST);
        quiet <= 1'b1;
        random_phase(250);

        drain();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/twcs_pkg.sv
rtl/twcs_mul.sv
rtl/twcs_div.sv
rtl/time_weighted_channel_stats.sv
tb/tb.sv
